// ===== hdl/sttok_pkg.sv =====
// Shared types, codes and constants of the source text tokenizer.
`timescale 1ns / 1ps

package sttok_pkg;

    localparam int OFFSET_BITS = 24;
    localparam int LINE_W      = 24;
    localparam int POS_W       = 25;
    localparam int NAME_W      = 24;
    localparam int VALUE_W     = 64;
    localparam int KW_LEN      = 8;
    localparam int KWP_W       = $clog2(KW_LEN + 1);
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic [LINE_W-1:0]      LINE_MAX   = {LINE_W{1'b1}};
    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

    typedef enum logic [3:0] {
        TK_END      = 4'd0,
        TK_KEYWORD  = 4'd1,
        TK_NAME     = 4'd2,
        TK_INTEGER  = 4'd3,
        TK_LPAREN   = 4'd4,
        TK_RPAREN   = 4'd5,
        TK_LBRACE   = 4'd6,
        TK_RBRACE   = 4'd7,
        TK_LBRACKET = 4'd8,
        TK_RBRACKET = 4'd9,
        TK_ERROR    = 4'd10
    } token_kind_t;

    typedef enum logic [2:0] {
        ERR_NONE          = 3'd0,
        ERR_UNKNOWN_CHAR  = 3'd1,
        ERR_BAD_SEPARATOR = 3'd2,
        ERR_ALPHA_IN_INT  = 3'd3,
        ERR_FLOAT         = 3'd4,
        ERR_RADIX         = 3'd5,
        ERR_SUFFIX        = 3'd6
    } error_code_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_NAME = 2'd1,
        PH_ZERO = 2'd2,
        PH_NUM  = 2'd3
    } lex_phase_t;

    // One queue entry: a full first token and an optional short second one.
    typedef struct packed {
        token_kind_t         kind;
        error_code_t         code;
        logic [LINE_W-1:0]   line;
        logic [POS_W-1:0]    pos;
        logic [VALUE_W-1:0]  value;
        logic [NAME_W-1:0]   name_start;
        logic [NAME_W-1:0]   name_length;
        logic                has_second;
        token_kind_t         kind2;
        error_code_t         code2;
        logic [POS_W-1:0]    pos2;
    } entry_t;

    function automatic logic [7:0] kw_char(input logic [KWP_W-2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = "f";
            3'd1:    ch = "u";
            3'd2:    ch = "n";
            3'd3:    ch = "c";
            3'd4:    ch = "t";
            3'd5:    ch = "i";
            3'd6:    ch = "o";
            3'd7:    ch = "n";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== hdl/sttok_front.sv =====
// Front end: accepts source bytes, runs the lexer state and forms queue entries.
`timescale 1ns / 1ps

module sttok_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_text_byte,
    input  logic                 s_end_marker,
    input  logic                 q_full,
    output logic                 q_push,
    output sttok_pkg::entry_t    q_entry,
    output logic                 halted
);

    sttok_pkg::lex_phase_t                  phase_reg, phase_next;
    logic                                   halted_reg, halted_next;
    logic [sttok_pkg::LINE_W-1:0]           line_reg, line_next;
    logic [sttok_pkg::OFFSET_BITS-1:0]      offset_reg, offset_next;
    logic [sttok_pkg::OFFSET_BITS-1:0]      start_reg, start_next;
    logic [sttok_pkg::VALUE_W-1:0]          value_reg, value_next;
    logic [sttok_pkg::KWP_W-1:0]            kwp_reg, kwp_next;
    logic                                   kwm_reg, kwm_next;
    logic                                   sep_pend_reg, sep_pend_next;
    logic                                   sep_fault_reg, sep_fault_next;
    logic [sttok_pkg::OFFSET_BITS-1:0]      sep_fpos_reg, sep_fpos_next;

    logic                                   accept;
    logic [7:0]                             c;
    logic                                   is_ws, is_dig, is_alp, is_us, is_word;
    logic [sttok_pkg::POS_W-1:0]            pos_here, pos_after, pos_fault;
    logic [sttok_pkg::VALUE_W-1:0]          digit_val, value_x10;

    // Idle-byte outcome, worked out for every byte
    logic                                   idle_emit, idle_fail;
    sttok_pkg::token_kind_t                 idle_kind;
    sttok_pkg::error_code_t                 idle_code;
    logic [sttok_pkg::POS_W-1:0]            idle_pos;

    logic                                   do_idle, idle_slot2, emit0;
    sttok_pkg::entry_t                      ent;

    assign accept  = s_valid && s_ready;
    assign s_ready = !q_full;
    assign halted  = halted_reg;
    assign c       = s_text_byte;

    assign is_ws   = (c == " ") || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
    assign is_dig  = (c >= "0") && (c <= "9");
    assign is_alp  = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    assign is_us   = (c == "_");
    assign is_word = is_alp || is_dig || is_us;

    assign pos_here  = sttok_pkg::POS_W'(offset_reg) + sttok_pkg::POS_W'(1);
    assign pos_after = sttok_pkg::POS_W'(offset_reg) + sttok_pkg::POS_W'(2);
    assign pos_fault = sttok_pkg::POS_W'(sep_fpos_reg) + sttok_pkg::POS_W'(1);

    assign digit_val = sttok_pkg::VALUE_W'(c - "0");
    assign value_x10 = {value_reg[sttok_pkg::VALUE_W-4:0], 3'b000}
                     + {value_reg[sttok_pkg::VALUE_W-2:0], 1'b0};

    always_comb begin
        idle_emit = 1'b0;
        idle_fail = 1'b0;
        idle_kind = sttok_pkg::TK_END;
        idle_code = sttok_pkg::ERR_NONE;
        idle_pos  = pos_after;
        if (!is_ws && !is_dig && !is_alp && !is_us) begin
            idle_emit = 1'b1;
            case (c)
                "(":     idle_kind = sttok_pkg::TK_LPAREN;
                ")":     idle_kind = sttok_pkg::TK_RPAREN;
                "{":     idle_kind = sttok_pkg::TK_LBRACE;
                "}":     idle_kind = sttok_pkg::TK_RBRACE;
                "[":     idle_kind = sttok_pkg::TK_LBRACKET;
                "]":     idle_kind = sttok_pkg::TK_RBRACKET;
                default: begin
                    idle_kind = sttok_pkg::TK_ERROR;
                    idle_code = sttok_pkg::ERR_UNKNOWN_CHAR;
                    idle_pos  = pos_here;
                    idle_fail = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        phase_next     = phase_reg;
        halted_next    = halted_reg;
        line_next      = line_reg;
        offset_next    = offset_reg;
        start_next     = start_reg;
        value_next     = value_reg;
        kwp_next       = kwp_reg;
        kwm_next       = kwm_reg;
        sep_pend_next  = sep_pend_reg;
        sep_fault_next = sep_fault_reg;
        sep_fpos_next  = sep_fpos_reg;

        do_idle    = 1'b0;
        idle_slot2 = 1'b0;
        emit0      = 1'b0;

        ent             = '0;
        ent.kind        = sttok_pkg::TK_END;
        ent.code        = sttok_pkg::ERR_NONE;
        ent.kind2       = sttok_pkg::TK_END;
        ent.code2       = sttok_pkg::ERR_NONE;
        ent.line        = line_reg;
        ent.pos         = pos_here;
        ent.pos2        = pos_here;

        if (accept && !halted_reg) begin
            if (s_end_marker) begin
                halted_next = 1'b1;
                phase_next  = sttok_pkg::PH_IDLE;
                emit0       = 1'b1;
                case (phase_reg)
                    sttok_pkg::PH_NAME: begin
                        if (kwm_reg && kwp_reg == sttok_pkg::KWP_W'(sttok_pkg::KW_LEN)) begin
                            ent.kind = sttok_pkg::TK_KEYWORD;
                        end else begin
                            ent.kind        = sttok_pkg::TK_NAME;
                            ent.name_start  = sttok_pkg::NAME_W'(start_reg);
                            ent.name_length = sttok_pkg::NAME_W'(offset_reg - start_reg);
                        end
                        ent.has_second = 1'b1;
                    end
                    sttok_pkg::PH_ZERO, sttok_pkg::PH_NUM: begin
                        if (sep_fault_reg) begin
                            ent.kind = sttok_pkg::TK_ERROR;
                            ent.code = sttok_pkg::ERR_BAD_SEPARATOR;
                            ent.pos  = pos_fault;
                        end else if (sep_pend_reg) begin
                            ent.kind = sttok_pkg::TK_ERROR;
                            ent.code = sttok_pkg::ERR_BAD_SEPARATOR;
                        end else begin
                            ent.kind       = sttok_pkg::TK_INTEGER;
                            ent.value      = value_reg;
                            ent.has_second = 1'b1;
                        end
                    end
                    default: ent.kind = sttok_pkg::TK_END;
                endcase
            end else begin
                if (offset_reg != sttok_pkg::OFFSET_MAX) begin
                    offset_next = offset_reg + sttok_pkg::OFFSET_BITS'(1);
                end
                case (phase_reg)
                    sttok_pkg::PH_NAME: begin
                        if (is_word) begin
                            if (kwm_reg && kwp_reg < sttok_pkg::KWP_W'(sttok_pkg::KW_LEN)
                                && c == sttok_pkg::kw_char(kwp_reg[sttok_pkg::KWP_W-2:0])) begin
                                kwp_next = kwp_reg + sttok_pkg::KWP_W'(1);
                            end else begin
                                kwm_next = 1'b0;
                            end
                        end else begin
                            emit0 = 1'b1;
                            if (kwm_reg && kwp_reg == sttok_pkg::KWP_W'(sttok_pkg::KW_LEN)) begin
                                ent.kind = sttok_pkg::TK_KEYWORD;
                            end else begin
                                ent.kind        = sttok_pkg::TK_NAME;
                                ent.name_start  = sttok_pkg::NAME_W'(start_reg);
                                ent.name_length = sttok_pkg::NAME_W'(offset_reg - start_reg);
                            end
                            do_idle    = 1'b1;
                            idle_slot2 = 1'b1;
                        end
                    end
                    sttok_pkg::PH_ZERO, sttok_pkg::PH_NUM: begin
                        if (phase_reg == sttok_pkg::PH_ZERO
                            && (c == "x" || c == "X" || c == "o" || c == "O"
                                || c == "b" || c == "B")) begin
                            emit0       = 1'b1;
                            halted_next = 1'b1;
                            ent.kind    = sttok_pkg::TK_ERROR;
                            ent.code    = sttok_pkg::ERR_RADIX;
                        end else if (is_dig) begin
                            if (!sep_fault_reg) begin
                                value_next = value_x10 + digit_val;
                            end
                            sep_pend_next = 1'b0;
                            phase_next    = sttok_pkg::PH_NUM;
                        end else if (is_us) begin
                            if (sep_pend_reg && !sep_fault_reg) begin
                                sep_fault_next = 1'b1;
                                sep_fpos_next  = offset_reg;
                            end
                            sep_pend_next = 1'b1;
                            phase_next    = sttok_pkg::PH_NUM;
                        end else if (c == "." || c == "e" || c == "E") begin
                            emit0       = 1'b1;
                            halted_next = 1'b1;
                            ent.kind    = sttok_pkg::TK_ERROR;
                            ent.code    = sttok_pkg::ERR_FLOAT;
                        end else if (sep_fault_reg) begin
                            emit0       = 1'b1;
                            halted_next = 1'b1;
                            ent.kind    = sttok_pkg::TK_ERROR;
                            ent.code    = sttok_pkg::ERR_BAD_SEPARATOR;
                            ent.pos     = pos_fault;
                        end else if (sep_pend_reg) begin
                            emit0       = 1'b1;
                            halted_next = 1'b1;
                            ent.kind    = sttok_pkg::TK_ERROR;
                            ent.code    = sttok_pkg::ERR_BAD_SEPARATOR;
                        end else if (c == "i" || c == "I") begin
                            emit0       = 1'b1;
                            halted_next = 1'b1;
                            ent.kind    = sttok_pkg::TK_ERROR;
                            ent.code    = sttok_pkg::ERR_SUFFIX;
                        end else if (is_alp) begin
                            emit0       = 1'b1;
                            halted_next = 1'b1;
                            ent.kind    = sttok_pkg::TK_ERROR;
                            ent.code    = sttok_pkg::ERR_ALPHA_IN_INT;
                        end else begin
                            emit0      = 1'b1;
                            ent.kind   = sttok_pkg::TK_INTEGER;
                            ent.value  = value_reg;
                            do_idle    = 1'b1;
                            idle_slot2 = 1'b1;
                        end
                    end
                    default: do_idle = 1'b1;
                endcase
            end

            // Handle the byte as the first byte of a fresh token
            if (do_idle) begin
                phase_next = sttok_pkg::PH_IDLE;
                if (is_ws) begin
                    if (c == 8'h0A && line_reg != sttok_pkg::LINE_MAX) begin
                        line_next = line_reg + sttok_pkg::LINE_W'(1);
                    end
                end else if (is_dig) begin
                    start_next     = offset_reg;
                    value_next     = digit_val;
                    sep_pend_next  = 1'b0;
                    sep_fault_next = 1'b0;
                    sep_fpos_next  = '0;
                    phase_next     = (c == "0") ? sttok_pkg::PH_ZERO : sttok_pkg::PH_NUM;
                end else if (is_alp || is_us) begin
                    start_next = offset_reg;
                    kwm_next   = (c == sttok_pkg::kw_char('0));
                    kwp_next   = (c == sttok_pkg::kw_char('0)) ? sttok_pkg::KWP_W'(1) : '0;
                    phase_next = sttok_pkg::PH_NAME;
                end
                if (idle_fail) begin
                    halted_next = 1'b1;
                end
                if (idle_emit) begin
                    if (idle_slot2) begin
                        ent.has_second = 1'b1;
                        ent.kind2      = idle_kind;
                        ent.code2      = idle_code;
                        ent.pos2       = idle_pos;
                    end else begin
                        emit0    = 1'b1;
                        ent.kind = idle_kind;
                        ent.code = idle_code;
                        ent.pos  = idle_pos;
                    end
                end
            end
        end
    end

    assign q_push  = emit0;
    assign q_entry = ent;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= sttok_pkg::PH_IDLE;
            halted_reg    <= 1'b0;
            line_reg      <= sttok_pkg::LINE_W'(1);
            offset_reg    <= '0;
            start_reg     <= '0;
            value_reg     <= '0;
            kwp_reg       <= '0;
            kwm_reg       <= 1'b1;
            sep_pend_reg  <= 1'b0;
            sep_fault_reg <= 1'b0;
            sep_fpos_reg  <= '0;
        end else begin
            phase_reg     <= phase_next;
            halted_reg    <= halted_next;
            line_reg      <= line_next;
            offset_reg    <= offset_next;
            start_reg     <= start_next;
            value_reg     <= value_next;
            kwp_reg       <= kwp_next;
            kwm_reg       <= kwm_next;
            sep_pend_reg  <= sep_pend_next;
            sep_fault_reg <= sep_fault_next;
            sep_fpos_reg  <= sep_fpos_next;
        end
    end

endmodule

// ===== hdl/sttok_fifo.sv =====
// Short token queue between the lexer front end and the output stage.
`timescale 1ns / 1ps

module sttok_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  sttok_pkg::entry_t    wr_entry,
    input  logic                 pop,
    output sttok_pkg::entry_t    rd_entry,
    output logic                 full,
    output logic                 empty
);

    sttok_pkg::entry_t                mem [sttok_pkg::Q_DEPTH];
    logic [sttok_pkg::Q_PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [sttok_pkg::Q_CNT_W-1:0]    count_reg;

    assign full     = (count_reg == sttok_pkg::Q_CNT_W'(sttok_pkg::Q_DEPTH));
    assign empty    = (count_reg == '0);
    assign rd_entry = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + sttok_pkg::Q_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + sttok_pkg::Q_PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + sttok_pkg::Q_CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - sttok_pkg::Q_CNT_W'(1);
            end
        end
    end

endmodule

// ===== hdl/sttok_back.sv =====
// Output stage: drains queue entries and shows one token per transfer.
`timescale 1ns / 1ps

module sttok_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  sttok_pkg::entry_t                   q_entry,
    input  logic                                q_empty,
    output logic                                q_pop,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [3:0]                          m_token_kind,
    output logic [2:0]                          m_error_code,
    output logic [sttok_pkg::LINE_W-1:0]        m_line_number,
    output logic [sttok_pkg::POS_W-1:0]         m_text_position,
    output logic signed [sttok_pkg::VALUE_W-1:0] m_integer_value,
    output logic [sttok_pkg::NAME_W-1:0]        m_name_start,
    output logic [sttok_pkg::NAME_W-1:0]        m_name_length,
    output logic                                m_run_end
);

    logic                               valid_reg;
    logic                               sec_pend_reg;
    sttok_pkg::token_kind_t             kind_reg, sec_kind_reg;
    sttok_pkg::error_code_t             code_reg, sec_code_reg;
    logic [sttok_pkg::LINE_W-1:0]       line_reg;
    logic [sttok_pkg::POS_W-1:0]        pos_reg, sec_pos_reg;
    logic [sttok_pkg::VALUE_W-1:0]      value_reg;
    logic [sttok_pkg::NAME_W-1:0]       nstart_reg, nlen_reg;
    logic                               run_end_reg;
    logic                               load;

    assign load  = !valid_reg || m_ready;
    assign q_pop = load && !sec_pend_reg && !q_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= 1'b0;
            sec_pend_reg <= 1'b0;
        end else if (load) begin
            if (sec_pend_reg) begin
                valid_reg    <= 1'b1;
                sec_pend_reg <= 1'b0;
            end else if (!q_empty) begin
                valid_reg    <= 1'b1;
                sec_pend_reg <= q_entry.has_second;
            end else begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Payload: the second token reuses the line of the first
    always_ff @(posedge aclk) begin
        if (load) begin
            if (sec_pend_reg) begin
                kind_reg    <= sec_kind_reg;
                code_reg    <= sec_code_reg;
                pos_reg     <= sec_pos_reg;
                value_reg   <= '0;
                nstart_reg  <= '0;
                nlen_reg    <= '0;
                run_end_reg <= 1'b1;
            end else if (!q_empty) begin
                kind_reg     <= q_entry.kind;
                code_reg     <= q_entry.code;
                line_reg     <= q_entry.line;
                pos_reg      <= q_entry.pos;
                value_reg    <= q_entry.value;
                nstart_reg   <= q_entry.name_start;
                nlen_reg     <= q_entry.name_length;
                run_end_reg  <= !q_entry.has_second;
                sec_kind_reg <= q_entry.kind2;
                sec_code_reg <= q_entry.code2;
                sec_pos_reg  <= q_entry.pos2;
            end
        end
    end

    assign m_valid         = valid_reg;
    assign m_token_kind    = kind_reg;
    assign m_error_code    = code_reg;
    assign m_line_number   = line_reg;
    assign m_text_position = pos_reg;
    assign m_integer_value = $signed(value_reg);
    assign m_name_start    = nstart_reg;
    assign m_name_length   = nlen_reg;
    assign m_run_end       = run_end_reg;

endmodule

// ===== hdl/source_text_tokenizer.sv =====
// Top level of the source text tokenizer: front end, token queue, output stage.
//
//   channel | direction | ports                           | transfer when
//   s_      | in        | s_text_byte, s_end_marker       | s_valid && s_ready
//   m_      | out       | m_token_kind .. m_run_end       | m_valid && m_ready
//
// One byte is taken per cycle unless the queue is full, and is lexed in that cycle.
// A byte that yields two tokens holds the output stage for two transfers.
// Tokens cross the queue, then the output register; the queue holds four entries.
// s_ready falls only while the queue is full. Reset is synchronous.
// After an error or end token, bytes are still taken but give no tokens.
`timescale 1ns / 1ps

module source_text_tokenizer (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [7:0]                           s_text_byte,
    input  logic                                 s_end_marker,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [3:0]                           m_token_kind,
    output logic [2:0]                           m_error_code,
    output logic [sttok_pkg::LINE_W-1:0]         m_line_number,
    output logic [sttok_pkg::POS_W-1:0]          m_text_position,
    output logic signed [sttok_pkg::VALUE_W-1:0] m_integer_value,
    output logic [sttok_pkg::NAME_W-1:0]         m_name_start,
    output logic [sttok_pkg::NAME_W-1:0]         m_name_length,
    output logic                                 m_run_end
);

    logic                 q_push, q_pop, q_full, q_empty, halted;
    sttok_pkg::entry_t    wr_entry, rd_entry;

    sttok_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_text_byte  (s_text_byte),
        .s_end_marker (s_end_marker),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_entry      (wr_entry),
        .halted       (halted)
    );

    sttok_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .wr_entry (wr_entry),
        .pop      (q_pop),
        .rd_entry (rd_entry),
        .full     (q_full),
        .empty    (q_empty)
    );

    sttok_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_entry         (rd_entry),
        .q_empty         (q_empty),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_token_kind    (m_token_kind),
        .m_error_code    (m_error_code),
        .m_line_number   (m_line_number),
        .m_text_position (m_text_position),
        .m_integer_value (m_integer_value),
        .m_name_start    (m_name_start),
        .m_name_length   (m_name_length),
        .m_run_end       (m_run_end)
    );

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("token queue written while full");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("token queue read while empty");

    a_halt_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        halted |=> halted && !q_push)
        else $error("token produced after halt");

    a_final_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_token_kind == sttok_pkg::TK_END
                    || m_token_kind == sttok_pkg::TK_ERROR) |-> m_run_end)
        else $error("end or error token not last of its byte");
`endif

endmodule
